>>> rtl/tphd_pkg.sv
// Package for the telemetry packet header deframer.
// Holds the sync constants, header layout, phase type and result record type.
// No dependencies.
`default_nettype none

package tphd_pkg;

   // sync word, first and second byte on the wire
   localparam logic [7:0] SyncFirst  = 8'h25;
   localparam logic [7:0] SyncSecond = 8'hEB;

   // full header is 24 bytes; 22 follow the sync word
   localparam logic [31:0] HeaderBytes     = 32'd24;
   localparam int          HeaderStoreDepth = 21;     // bytes kept before the last one
   localparam logic [4:0]  HeaderLastPos   = 5'd21;  // position of the final header byte

   // result kinds carried on tuser
   localparam logic KindHeader  = 1'b0;
   localparam logic KindPayload = 1'b1;

   // receive phase
   typedef enum logic [1:0] {
      PH_PAIR_A,
      PH_PAIR_B,
      PH_HEADER,
      PH_PAYLOAD
   } phase_type;

   // one result record
   typedef struct packed {
      logic        result_kind;
      logic [15:0] channel_id;
      logic [31:0] packet_length;
      logic [31:0] body_length;
      logic [7:0]  type_version;
      logic [7:0]  sequence_number;
      logic [7:0]  packet_flags;
      logic [7:0]  data_type;
      logic [47:0] relative_time;
      logic [15:0] header_checksum;
      logic [7:0]  payload_byte;
      logic        payload_last;
   } res_type;

endpackage : tphd_pkg

`default_nettype wire

>>> rtl/telemetry_packet_header_deframer.sv
// Sync bytes and header bytes before the last give no result; other results are registered.
// Throughput: one input byte per cycle while req_tready is high.
// req_tready depends only on the skid register, so input keeps flowing while one result waits.
// Reset (synchronous, active high) returns to the sync hunt and empties the output stages.
// Top level: instantiates tphd_parser and tphd_skid; depends on tphd_pkg.
`default_nettype none

module telemetry_packet_header_deframer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,   // data_byte[7:0]
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [183:0] rsp_tdata,   // channel_id, packet_length, body_length,
                                          // type_version, sequence_number, packet_flags,
                                          // data_type, relative_time, header_checksum,
                                          // payload_byte (lowest bit up)
   output      logic         rsp_tuser,   // result_kind
   output      logic         rsp_tlast    // payload_last
);
   import tphd_pkg::*;

   logic    in_fire;
   logic    res_valid;
   res_type res;
   res_type out_rec;

   assign in_fire = req_tvalid && req_tready;

   tphd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .in_byte   (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   tphd_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res),
      .space_ok   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (out_rec),
      .out_ready  (rsp_tready)
   );

   // pack the record onto the stream
   assign rsp_tdata = {out_rec.payload_byte, out_rec.header_checksum, out_rec.relative_time,
                       out_rec.data_type, out_rec.packet_flags, out_rec.sequence_number,
                       out_rec.type_version, out_rec.body_length, out_rec.packet_length,
                       out_rec.channel_id};
   assign rsp_tuser = out_rec.result_kind;
   assign rsp_tlast = out_rec.payload_last;

endmodule : telemetry_packet_header_deframer

`default_nettype wire

>>> rtl/tphd_parser.sv
// Header parser: sync hunt, header byte capture, field assembly and payload count.
// Produces at most one result record per accepted byte. Depends on tphd_pkg.
`default_nettype none

module tphd_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_fire,
   input  wire logic [7:0]       in_byte,
   output      logic             res_valid,
   output      tphd_pkg::res_type res
);
   import tphd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        first_sync_ff, first_sync_in;
   logic [4:0]  header_pos_ff, header_pos_in;
   logic [31:0] payload_remaining_ff, payload_remaining_in;
   logic [7:0]  header_store_ff [0:HeaderStoreDepth-1];
   logic [7:0]  hdr [0:21];
   logic [31:0] plen;

   // full header view: stored bytes plus the byte arriving now
   always_comb begin
      for (int k = 0; k < HeaderStoreDepth; k++) begin
         hdr[k] = header_store_ff[k];
      end
      hdr[21] = in_byte;
   end

   assign plen = {hdr[5], hdr[4], hdr[3], hdr[2]};

   // next state and result
   always_comb begin
      phase_in             = phase_ff;
      first_sync_in        = first_sync_ff;
      header_pos_in        = header_pos_ff;
      payload_remaining_in = payload_remaining_ff;
      res_valid            = 1'b0;
      res                  = '0;
      if (in_fire) begin
         unique case (phase_ff)
            PH_PAIR_A: begin
               first_sync_in = (in_byte == SyncFirst);
               phase_in      = PH_PAIR_B;
            end
            PH_PAIR_B: begin
               if (first_sync_ff && (in_byte == SyncSecond)) begin
                  header_pos_in = '0;
                  phase_in      = PH_HEADER;
               end else begin
                  phase_in = PH_PAIR_A;
               end
               first_sync_in = 1'b0;
            end
            PH_HEADER: begin
               if (header_pos_ff == HeaderLastPos) begin
                  header_pos_in       = '0;
                  res_valid           = 1'b1;
                  res.result_kind     = KindHeader;
                  res.channel_id      = {hdr[1], hdr[0]};
                  res.packet_length   = plen;
                  res.body_length     = {hdr[9], hdr[8], hdr[7], hdr[6]};
                  res.type_version    = hdr[10];
                  res.sequence_number = hdr[11];
                  res.packet_flags    = hdr[12];
                  res.data_type       = hdr[13];
                  res.relative_time   = {hdr[19], hdr[18], hdr[17], hdr[16], hdr[15], hdr[14]};
                  res.header_checksum = {hdr[21], hdr[20]};
                  // payload follows only when the length exceeds the header
                  if (plen > HeaderBytes) begin
                     payload_remaining_in = plen - HeaderBytes;
                     phase_in             = PH_PAYLOAD;
                  end else begin
                     payload_remaining_in = '0;
                     phase_in             = PH_PAIR_A;
                  end
               end else begin
                  header_pos_in = header_pos_ff + 5'd1;
               end
            end
            PH_PAYLOAD: begin
               res_valid            = 1'b1;
               res.result_kind      = KindPayload;
               res.payload_byte     = in_byte;
               payload_remaining_in = payload_remaining_ff - 32'd1;
               if (payload_remaining_ff == 32'd1) begin
                  res.payload_last = 1'b1;
                  phase_in         = PH_PAIR_A;
                  first_sync_in    = 1'b0;
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff             <= PH_PAIR_A;
         first_sync_ff        <= 1'b0;
         header_pos_ff        <= '0;
         payload_remaining_ff <= '0;
      end else begin
         phase_ff             <= phase_in;
         first_sync_ff        <= first_sync_in;
         header_pos_ff        <= header_pos_in;
         payload_remaining_ff <= payload_remaining_in;
      end
   end

   // header bytes carry no reset
   always_ff @(posedge clock) begin
      if (in_fire && (phase_ff == PH_HEADER) && (header_pos_ff != HeaderLastPos)) begin
         header_store_ff[header_pos_ff] <= in_byte;
      end
   end

   // the header position never runs past the final byte
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (header_pos_ff <= HeaderLastPos))
      else $error("header position out of range");

   // payload phase always has bytes left to pass
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (payload_remaining_ff != 32'd0))
      else $error("payload phase with zero count");

   // sync bytes never give a result
   a_sync_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAIR_A || phase_ff == PH_PAIR_B) |-> !res_valid)
      else $error("result during sync hunt");

   // a completed header leaves the header phase
   a_header_done: assert property (@(posedge clock) disable iff (reset)
      (in_fire && phase_ff == PH_HEADER && header_pos_ff == HeaderLastPos)
      |=> (phase_ff != PH_HEADER))
      else $error("header phase did not end");

endmodule : tphd_parser

`default_nettype wire

>>> rtl/tphd_skid.sv
// Result output register with a skid stage, so input acceptance waits on rsp_tready only once the skid is full.
// Depends on tphd_pkg.
`default_nettype none

module tphd_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire tphd_pkg::res_type push_data,
   output      logic              space_ok,
   output      logic              out_valid,
   output      tphd_pkg::res_type out_data,
   input  wire logic              out_ready
);
   import tphd_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   res_type out_data_ff, out_data_in;
   res_type skid_data_ff, skid_data_in;

   // advance skid into output; park a new transaction when output is held
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push_valid;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push_valid;
            out_data_in  = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space_ok  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // skid holds data only behind a full output register
   a_skid_behind: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid full with empty output");

   // a draining skid refills the output register
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> out_valid_ff)
      else $error("skid transaction lost");

   // no push arrives while the skid is full and the output is held
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_ready |-> !push_valid)
      else $error("push into full skid");

endmodule : tphd_skid

`default_nettype wire
